// ----- src/rgb_to_hsv_pixel_macros.svh -----
// ---------------------------------------------------------------------------
// RGB to HSV pixel converter assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_MACROS_SVH
`define RGB_TO_HSV_PIXEL_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTH_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error("rgb_to_hsv_pixel: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RTH_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error("rgb_to_hsv_pixel: next-cycle check failed");

`endif

// ----- src/rth_pkg.sv -----
// ---------------------------------------------------------------------------
// RGB to HSV pixel converter package
// Payload types, stage records, constants and the divider step function.
// ---------------------------------------------------------------------------
package rth_pkg;

    localparam int CHAN_W     = 8;
    localparam int HUE_W      = 8;
    localparam int PCT_W      = 7;
    localparam int NUM_W      = 15;  // widest dividend: 255 * 100
    localparam int QUO_W      = 7;   // widest quotient: 100
    localparam int DIV_STAGES = 4;   // up to two quotient bits per stage

    localparam logic [HUE_W-1:0] HUE_GREEN = 8'd60;
    localparam logic [HUE_W-1:0] HUE_BLUE  = 8'd120;
    localparam logic [HUE_W-1:0] HUE_WRAP  = 8'd180;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] brightness;
    } hsv_t;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // After the max/min compare.
    typedef struct packed {
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] mn;
        logic signed [CHAN_W:0] diff;
        sector_t           sector;
    } stg_a_t;

    // Dividends and divisors ready.
    typedef struct packed {
        logic [NUM_W-1:0]  num_h;
        logic [NUM_W-1:0]  num_s;
        logic [NUM_W-1:0]  x_v;
        logic [CHAN_W-1:0] d;
        logic [CHAN_W-1:0] mx;
        logic              neg;
        logic              gray;
        logic              mx_zero;
        sector_t           sector;
    } stg_b_t;

    // One divider stage.
    typedef struct packed {
        logic [NUM_W-1:0]  rem_h;
        logic [NUM_W-1:0]  rem_s;
        logic [CHAN_W-1:0] dv_h;
        logic [CHAN_W-1:0] dv_s;
        logic [QUO_W-1:0]  q_h;
        logic [QUO_W-1:0]  q_s;
        logic [NUM_W-1:0]  x_v;
        logic [PCT_W-1:0]  val;
        logic              neg;
        logic              gray;
        logic              mx_zero;
        sector_t           sector;
    } stg_c_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic             qbit;
    } div_res_t;

    // One restoring division step for quotient bit k.
    function automatic div_res_t div_bit(input logic [NUM_W-1:0] rem,
                                         input logic [CHAN_W-1:0] dvs,
                                         input logic [2:0] k);
        logic [NUM_W-1:0] sh;
        div_res_t         res;
        sh = NUM_W'(dvs) << k;
        if (rem >= sh) begin
            res.rem  = rem - sh;
            res.qbit = 1'b1;
        end else begin
            res.rem  = rem;
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

// ----- src/rgb_to_hsv_pixel.sv -----
// ---------------------------------------------------------------------------
// RGB to HSV pixel converter
// Converts one 8-bit RGB pixel per cycle, when not stalled, into hue, saturation and value.
// ---------------------------------------------------------------------------
// The input channel (s_valid, s_ready, s_data) takes one pixel per transfer,
// and the result channel (m_valid, m_ready, m_data) gives one HSV triple per
// transfer, in the order the pixels came in. Hue is in half degrees, 0..179;
// saturation and value are in percent, 0..100.
// The datapath is a seven-stage pipeline: max/min compare, dividend
// products, four restoring divider stages (up to two quotient bits each,
// with the value scaling carried alongside) and the output register that
// also applies the sector offset. An accepted pixel passes through the
// stage registers in order. Throughput is one pixel per cycle while the
// receiver does not stall; every stage has its own valid bit.
// When the receiver holds m_ready low, the stages fill up behind the
// output register: empty stages still take data, so bubbles close up, and
// s_ready falls only once every stage holds a pixel. Nothing is dropped or
// repeated. Synchronous reset clears all valid bits; the payload registers
// are not reset, and the block is ready in the first cycle after reset.
// ---------------------------------------------------------------------------
`include "rgb_to_hsv_pixel_macros.svh"

module rgb_to_hsv_pixel
    import rth_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  pixel_t s_data,
    output logic   m_valid,
    input  logic   m_ready,
    output hsv_t   m_data
);

    stg_a_t a_reg, a_next;
    logic   a_valid_reg;
    stg_b_t b_reg, b_next;
    logic   b_valid_reg;
    stg_c_t c_reg  [DIV_STAGES];
    stg_c_t c_next [DIV_STAGES];
    logic   c_valid_reg [DIV_STAGES];
    hsv_t   m_data_reg, m_data_next;
    logic   m_valid_reg;

    // A stage may load when it is empty or its content moves on.
    logic en_out;
    logic en_c [DIV_STAGES];
    logic en_b;
    logic en_a;

    always_comb begin
        en_out = !m_valid_reg || m_ready;
        en_c[DIV_STAGES-1] = !c_valid_reg[DIV_STAGES-1] || en_out;
        for (int j = DIV_STAGES - 2; j >= 0; j--) begin
            en_c[j] = !c_valid_reg[j] || en_c[j+1];
        end
        en_b = !b_valid_reg || en_c[0];
        en_a = !a_valid_reg || en_b;
    end

    assign s_ready = en_a;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Stage A: channel maximum, minimum and the winning sector. On ties the
    // later sector wins, so blue beats green and green beats red.
    always_comb begin
        a_next.mx = s_data.red;
        a_next.mn = s_data.red;
        if (s_data.green > a_next.mx) a_next.mx = s_data.green;
        if (s_data.blue  > a_next.mx) a_next.mx = s_data.blue;
        if (s_data.green < a_next.mn) a_next.mn = s_data.green;
        if (s_data.blue  < a_next.mn) a_next.mn = s_data.blue;
        priority if (s_data.blue >= s_data.red && s_data.blue >= s_data.green) begin
            a_next.sector = SEC_BLUE;
            a_next.diff   = $signed({1'b0, s_data.red}) - $signed({1'b0, s_data.green});
        end else if (s_data.green >= s_data.red) begin
            a_next.sector = SEC_GREEN;
            a_next.diff   = $signed({1'b0, s_data.blue}) - $signed({1'b0, s_data.red});
        end else begin
            a_next.sector = SEC_RED;
            a_next.diff   = $signed({1'b0, s_data.green}) - $signed({1'b0, s_data.blue});
        end
    end

    // Stage B: spread and the dividends. Truncating division is symmetric,
    // so the hue quotient is formed on the magnitude and the sign is kept.
    always_comb begin
        logic [CHAN_W:0] mag;
        b_next.d       = a_reg.mx - a_reg.mn;
        b_next.neg     = a_reg.diff[CHAN_W];
        mag            = b_next.neg ? (CHAN_W+1)'(-a_reg.diff) : (CHAN_W+1)'(a_reg.diff);
        b_next.num_h   = NUM_W'(mag[CHAN_W-1:0]) * NUM_W'(60);
        b_next.num_s   = NUM_W'(b_next.d) * NUM_W'(100);
        b_next.x_v     = NUM_W'(a_reg.mx) * NUM_W'(100);
        b_next.mx      = a_reg.mx;
        b_next.gray    = (b_next.d == '0);
        b_next.mx_zero = (a_reg.mx == '0);
        b_next.sector  = a_reg.sector;
    end

    // Divider stages. Each handles up to two quotient bits of both divisions. The
    // value is x / 255 for x = 100 * mx: the first stage takes the estimate
    // x * 257 >> 16, which is low by at most one, and the second corrects it.
    always_comb begin
        stg_c_t           cur;
        div_res_t         rh;
        div_res_t         rs;
        logic [23:0]      prod;
        logic [NUM_W-1:0] rem_v;
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (j == 0) begin
                cur.rem_h   = b_reg.num_h;
                cur.rem_s   = b_reg.num_s;
                cur.dv_h    = b_reg.d;
                cur.dv_s    = b_reg.mx;
                cur.q_h     = '0;
                cur.q_s     = '0;
                cur.x_v     = b_reg.x_v;
                cur.val     = '0;
                cur.neg     = b_reg.neg;
                cur.gray    = b_reg.gray;
                cur.mx_zero = b_reg.mx_zero;
                cur.sector  = b_reg.sector;
            end else begin
                cur = c_reg[j-1];
            end
            for (int s = 0; s < 2; s++) begin
                if (QUO_W - 1 - 2 * j - s >= 0) begin
                    rh = div_bit(cur.rem_h, cur.dv_h, 3'(QUO_W - 1 - 2 * j - s));
                    rs = div_bit(cur.rem_s, cur.dv_s, 3'(QUO_W - 1 - 2 * j - s));
                    cur.rem_h = rh.rem;
                    cur.rem_s = rs.rem;
                    cur.q_h[3'(QUO_W - 1 - 2 * j - s)] = rh.qbit;
                    cur.q_s[3'(QUO_W - 1 - 2 * j - s)] = rs.qbit;
                end
            end
            if (j == 0) begin
                prod    = 24'(cur.x_v) * 24'd257;
                cur.val = prod[22:16];
            end else if (j == 1) begin
                rem_v = cur.x_v - NUM_W'(cur.val) * NUM_W'(255);
                if (rem_v >= NUM_W'(255)) begin
                    cur.val = cur.val + PCT_W'(1);
                end
            end
            c_next[j] = cur;
        end
    end

    // Output stage: halve the hue quotient toward zero and add the sector
    // offset. Only the red sector can go negative; it wraps by 180. A
    // negative quotient that halves to zero gives hue 0.
    always_comb begin
        stg_c_t            last;
        logic [HUE_W-1:0]  half;
        last = c_reg[DIV_STAGES-1];
        half = HUE_W'(last.q_h[QUO_W-1:1]);
        if (last.gray) begin
            m_data_next.hue = '0;
        end else begin
            unique case (last.sector)
                SEC_RED: begin
                    m_data_next.hue = (last.neg && half != '0) ? HUE_WRAP - half : half;
                end
                SEC_GREEN: begin
                    m_data_next.hue = last.neg ? HUE_GREEN - half : HUE_GREEN + half;
                end
                SEC_BLUE: begin
                    m_data_next.hue = last.neg ? HUE_BLUE - half : HUE_BLUE + half;
                end
                default: begin
                    m_data_next.hue = '0;
                end
            endcase
        end
        m_data_next.saturation = last.mx_zero ? '0 : last.q_s;
        m_data_next.brightness = last.val;
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            for (int j = 0; j < DIV_STAGES; j++) begin
                c_valid_reg[j] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            if (en_a) a_valid_reg <= s_valid;
            if (en_b) b_valid_reg <= a_valid_reg;
            if (en_c[0]) c_valid_reg[0] <= b_valid_reg;
            for (int j = 1; j < DIV_STAGES; j++) begin
                if (en_c[j]) c_valid_reg[j] <= c_valid_reg[j-1];
            end
            if (en_out) m_valid_reg <= c_valid_reg[DIV_STAGES-1];
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (en_a) a_reg <= a_next;
        if (en_b) b_reg <= b_next;
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (en_c[j]) c_reg[j] <= c_next[j];
        end
        if (en_out) m_data_reg <= m_data_next;
    end

    // A presented result is always in range.
    `RTH_ASSERT_NOW(a_out_range, m_valid_reg,
        m_data_reg.hue < HUE_WRAP && m_data_reg.saturation <= PCT_W'(100) &&
        m_data_reg.brightness <= PCT_W'(100))
    // An accepted pixel is held in the first stage.
    `RTH_ASSERT_NEXT(a_in_captured, s_valid && s_ready, a_valid_reg)
    // A stalled last divider stage keeps its item.
    `RTH_ASSERT_NEXT(a_tail_holds,
        c_valid_reg[DIV_STAGES-1] && m_valid_reg && !m_ready,
        c_valid_reg[DIV_STAGES-1] && $stable(c_reg[DIV_STAGES-1]))
    // A result only appears when the last divider stage held one.
    `RTH_ASSERT_NOW(a_out_source, $rose(m_valid_reg), $past(c_valid_reg[DIV_STAGES-1]))

endmodule
